>>> hw/rtl/cba_pkg.sv
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the contiguous block allocator: field
// widths, result kinds and the command/status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int SIZE_W           = 9;
  localparam int START_W          = 6;
  localparam int FREE_W           = 9;
  localparam int FREE_MAX         = 511;
  localparam int BLOCK_COUNT_DEF  = 64;
  localparam int KB_PER_BLOCK_DEF = 4;

  typedef enum logic [1:0] {
    RES_FAIL,
    RES_ALLOC,
    RES_CLEAR
  } res_kind_t;

  typedef struct packed {
    logic      ptr_clr;
    logic      sweep_en;
    logic      load;
    logic      div1;
    logic      div2;
    logic      scan_start;
    logic      scan_en;
    logic      mark_en;
    logic      res_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic need_bad;
    logic hit;
    logic miss_end;
    logic mark_last;
  } status_t;

endpackage

>>> hw/rtl/contiguous_block_allocator.sv
// ----------------------------------------------------------------------------
// contiguous_block_allocator
// First-fit contiguous block allocator over a free map of BLOCK_COUNT blocks
// of KB_PER_BLOCK KB each; block zero is reserved.
//
// Input channel (in_valid/in_ready): one word carries action and size_kb.
// Allocate (action 0) turns size_kb into a block count, marks the lowest
// free run of that length and returns its start; clear (action 1) restores
// the reset map. Output channel (out_valid/out_ready): one word per input
// with ok, start_block and the free space left in KB.
// Allocate computes the block count, checks it, then scans the map, one
// map read per cycle, and marks the found run block by block; a request
// with zero blocks or too many fails before the scan. Clear sweeps the
// map, one map write per cycle. One word is in work at a time; the map
// RAM has a single port pair.
// Reset: the block runs a clearing pass over the map with in_ready low. A
// stalled receiver holds the result word; the next input word is still
// taken, and its result waits until the slot frees.
// ----------------------------------------------------------------------------
module contiguous_block_allocator
  import cba_pkg::*;
#(
  parameter int BLOCK_COUNT  = BLOCK_COUNT_DEF,
  parameter int KB_PER_BLOCK = KB_PER_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [SIZE_W-1:0]  size_kb,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               ok,
  output logic [START_W-1:0] start_block,
  output logic [FREE_W-1:0]  free_kb
);

  cmd_t    cmd;
  status_t status;

  cba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .status   (status)
  );

  cba_dp #(
    .BLOCK_COUNT (BLOCK_COUNT),
    .KB_PER_BLOCK(KB_PER_BLOCK)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .status     (status),
    .size_kb    (size_kb),
    .ok         (ok),
    .start_block(start_block),
    .free_kb    (free_kb)
  );

endmodule

>>> hw/rtl/cba_ram.sv
// ----------------------------------------------------------------------------
// cba_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/cba_dp.sv
// ----------------------------------------------------------------------------
// cba_dp
// Allocator datapath: free map RAM, block count by reciprocal
// multiplication, first-fit run tracker, marking pointer, free counter and
// result register.
// ----------------------------------------------------------------------------
module cba_dp
  import cba_pkg::*;
#(
  parameter int BLOCK_COUNT  = BLOCK_COUNT_DEF,
  parameter int KB_PER_BLOCK = KB_PER_BLOCK_DEF
) (
  input  logic               clk,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [SIZE_W-1:0]  size_kb,
  output logic               ok,
  output logic [START_W-1:0] start_block,
  output logic [FREE_W-1:0]  free_kb
);

  localparam int AW    = $clog2(BLOCK_COUNT);
  localparam int RW    = $clog2(BLOCK_COUNT + 1);
  localparam int KBW   = RW + 7;
  localparam int RECIP = (1 << 16) / KB_PER_BLOCK;
  localparam logic [16:0]   RECIP_V = 17'(RECIP);
  localparam logic [15:0]   KB_V    = 16'(KB_PER_BLOCK);
  localparam logic [AW-1:0] LAST    = AW'(BLOCK_COUNT - 1);

  logic [SIZE_W-1:0]    size_q;
  logic [SIZE_W-1:0]    q0;
  logic [SIZE_W-1:0]    need;
  logic [SIZE_W+16:0]   prod;
  logic [15:0]          rem;

  logic [AW-1:0]        wr_ptr;
  logic [RW-1:0]        mark_cnt;
  logic [AW-1:0]        rd_addr;
  logic                 issue;
  logic                 d_valid;
  logic [AW-1:0]        d_idx;
  logic [RW-1:0]        run;
  logic [AW-1:0]        run_start;
  logic [AW-1:0]        start_cur;
  logic [AW-1:0]        start_q;
  logic [RW-1:0]        free_count;
  logic [KBW-1:0]       kb_full;
  logic [AW+5:0]        start_ext;

  logic                 ram_we;
  logic [0:0]           ram_wdata;
  logic [0:0]           ram_rdata;

  cba_ram #(
    .WIDTH(1),
    .DEPTH(BLOCK_COUNT)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  assign ram_we    = cmd.sweep_en | cmd.mark_en;
  assign ram_wdata = cmd.sweep_en && (wr_ptr != '0);

  assign prod      = (SIZE_W + 17)'(size_q) * (SIZE_W + 17)'(RECIP_V);
  assign rem       = 16'(size_q) - 16'(q0) * KB_V;
  assign start_cur = (run == '0) ? d_idx : run_start;
  assign kb_full   = KBW'(free_count) * KBW'(KB_PER_BLOCK);
  assign start_ext = (AW + 6)'(start_q);

  assign status.sweep_last = (wr_ptr == LAST);
  assign status.need_bad   = (need == '0) || (int'(need) > BLOCK_COUNT);
  assign status.hit        = d_valid && ram_rdata[0] &&
                             (((RW + 1)'(run) + (RW + 1)'(1)) == (RW + 1)'(need));
  assign status.miss_end   = d_valid && (d_idx == LAST) && !status.hit;
  assign status.mark_last  = (mark_cnt == RW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      size_q <= size_kb;
    end
    if (cmd.div1) begin
      q0 <= prod[16 +: SIZE_W];
    end
    if (cmd.div2) begin
      need <= q0 + SIZE_W'(rem >= KB_V);
    end

    if (cmd.ptr_clr) begin
      wr_ptr <= '0;
    end else if (cmd.sweep_en) begin
      wr_ptr <= wr_ptr + AW'(1);
      if (status.sweep_last) begin
        free_count <= RW'(BLOCK_COUNT - 1);
      end
    end else if (cmd.mark_en) begin
      wr_ptr   <= wr_ptr + AW'(1);
      mark_cnt <= mark_cnt - RW'(1);
    end else if (cmd.scan_en && status.hit) begin
      wr_ptr     <= start_cur;
      start_q    <= start_cur;
      mark_cnt   <= RW'(need);
      free_count <= free_count - RW'(need);
    end

    if (cmd.scan_start) begin
      rd_addr <= '0;
      issue   <= 1'b1;
      d_valid <= 1'b0;
      run     <= '0;
    end else if (cmd.scan_en) begin
      d_valid <= issue;
      d_idx   <= rd_addr;
      if (issue) begin
        if (rd_addr == LAST) begin
          issue <= 1'b0;
        end else begin
          rd_addr <= rd_addr + AW'(1);
        end
      end
      if (d_valid) begin
        if (ram_rdata[0]) begin
          if (run == '0) begin
            run_start <= d_idx;
          end
          run <= run + RW'(1);
        end else begin
          run <= '0;
        end
      end
    end

    if (cmd.res_load) begin
      ok          <= (cmd.res_kind != RES_FAIL);
      start_block <= (cmd.res_kind == RES_ALLOC) ? start_ext[START_W-1:0] : '0;
      free_kb     <= (kb_full > KBW'(FREE_MAX)) ? FREE_W'(FREE_MAX) : kb_full[FREE_W-1:0];
    end
  end

endmodule

>>> hw/rtl/cba_ctrl.sv
// ----------------------------------------------------------------------------
// cba_ctrl
// Allocator controller: sequences map sweeps, block count, first-fit scan,
// marking and the result word; owns both handshakes.
// ----------------------------------------------------------------------------
module cba_ctrl
  import cba_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    action,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  typedef enum logic [3:0] {
    S_INIT,
    S_SWEEP,
    S_IDLE,
    S_DIV1,
    S_DIV2,
    S_CHECK,
    S_SCAN,
    S_MARK,
    S_RESULT
  } state_t;

  state_t    state;
  res_kind_t kind;
  logic      clearing;
  logic      accept;
  logic      slot_free;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.res_kind = kind;
    unique case (state)
      S_INIT:   cmd.ptr_clr    = 1'b1;
      S_SWEEP:  cmd.sweep_en   = 1'b1;
      S_IDLE: begin
        cmd.load    = accept;
        cmd.ptr_clr = accept && action;
      end
      S_DIV1:   cmd.div1       = 1'b1;
      S_DIV2:   cmd.div2       = 1'b1;
      S_CHECK:  cmd.scan_start = !status.need_bad;
      S_SCAN:   cmd.scan_en    = 1'b1;
      S_MARK:   cmd.mark_en    = 1'b1;
      S_RESULT: cmd.res_load   = slot_free;
      default:  cmd            = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      kind      <= RES_FAIL;
      clearing  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_RESULT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_INIT: begin
          clearing <= 1'b0;
          state    <= S_SWEEP;
        end
        S_SWEEP: begin
          if (status.sweep_last) begin
            kind  <= RES_CLEAR;
            state <= clearing ? S_RESULT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            clearing <= action;
            state    <= action ? S_SWEEP : S_DIV1;
          end
        end
        S_DIV1:  state <= S_DIV2;
        S_DIV2:  state <= S_CHECK;
        S_CHECK: begin
          if (status.need_bad) begin
            kind  <= RES_FAIL;
            state <= S_RESULT;
          end else begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (status.hit) begin
            state <= S_MARK;
          end else if (status.miss_end) begin
            kind  <= RES_FAIL;
            state <= S_RESULT;
          end
        end
        S_MARK: begin
          if (status.mark_last) begin
            kind  <= RES_ALLOC;
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

endmodule

>>> tb/sv/tb_cba_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cba_pkg
// Action codes and the result word layout shared by the allocator test
// stimulus and the allocator checker.
// ----------------------------------------------------------------------------
package tb_cba_pkg;
  import cba_pkg::*;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic               ok;
    logic [START_W-1:0] start_block;
    logic [FREE_W-1:0]  free_kb;
  } alloc_result_t;

endpackage

>>> tb/sv/cba_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cba_alloc_checker
// Watches both channels of the contiguous block allocator. Keeps its own
// free map, works out the result word of every accepted request and
// compares each returned word, field by field, with the oldest one pending.
// ----------------------------------------------------------------------------
module cba_alloc_checker
  import cba_pkg::*;
  import tb_cba_pkg::*;
#(
  parameter int BLOCK_COUNT  = BLOCK_COUNT_DEF,
  parameter int KB_PER_BLOCK = KB_PER_BLOCK_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               action,
  input  logic [SIZE_W-1:0]  size_kb,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               ok,
  input  logic [START_W-1:0] start_block,
  input  logic [FREE_W-1:0]  free_kb,
  output int                 errors,
  output int                 pending,
  output int                 words_checked,
  output int                 fits,
  output int                 misses,
  output int                 clears
);

  bit [BLOCK_COUNT-1:0] free_map;
  int unsigned          free_blocks;
  alloc_result_t        result_q[$];
  alloc_result_t        want;
  alloc_result_t        got;

  function automatic void restore_map();
    free_map    = '1;
    free_map[0] = 1'b0;
    free_blocks = BLOCK_COUNT - 1;
  endfunction

  // First fit over the whole map, last block included.
  function automatic alloc_result_t apply_request(logic act, logic [SIZE_W-1:0] kb);
    alloc_result_t r;
    int unsigned   need;
    int unsigned   run;
    int unsigned   kb_left;
    int unsigned   first;
    int            i;
    int            k;
    r   = '0;
    run = 0;
    if (act == ACT_CLEAR) begin
      restore_map();
      r.ok = 1'b1;
    end else begin
      need = kb / KB_PER_BLOCK;
      if (need != 0 && need <= BLOCK_COUNT) begin
        for (i = 0; i < BLOCK_COUNT && !r.ok; i++) begin
          if (free_map[i]) begin
            run++;
            if (run == need) begin
              first = i + 1 - need;
              for (k = first; k <= i; k++) free_map[k] = 1'b0;
              free_blocks   -= need;
              r.ok          = 1'b1;
              r.start_block = first[START_W-1:0];
            end
          end else begin
            run = 0;
          end
        end
      end
    end
    kb_left = free_blocks * KB_PER_BLOCK;
    if (kb_left > FREE_MAX) kb_left = FREE_MAX;
    r.free_kb = kb_left[FREE_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      restore_map();
      result_q.delete();
      errors        = 0;
      words_checked = 0;
      fits          = 0;
      misses        = 0;
      clears        = 0;
    end else begin
      if (in_valid && in_ready) begin
        want = apply_request(action, size_kb);
        if (action == ACT_CLEAR) clears++;
        else if (want.ok) fits++;
        else misses++;
        result_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{ok: ok, start_block: start_block, free_kb: free_kb};
        if (result_q.size() == 0) begin
          errors++;
          $display("%0t: result word with none expected, actual ok %0d start %0d free %0d",
                   $time, got.ok, got.start_block, got.free_kb);
        end else begin
          want = result_q.pop_front();
          check_field("ok", 32'(want.ok), 32'(got.ok));
          check_field("start_block", 32'(want.start_block), 32'(got.start_block));
          check_field("free_kb", 32'(want.free_kb), 32'(got.free_kb));
          words_checked++;
        end
      end
    end
    pending = result_q.size();
  end

endmodule

>>> tb/sv/tb_contiguous_block_allocator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_contiguous_block_allocator
// Drives allocate and clear words into the allocator: a directed opening
// on zero-block, oversize, full-map and last-block requests, then random
// fill-and-clear sequences under four sender/receiver idling mixes. The
// checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_contiguous_block_allocator
  import cba_pkg::*;
  import tb_cba_pkg::*;
();

  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 200;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               action    = ACT_ALLOC;
  logic [SIZE_W-1:0]  size_kb   = '0;
  logic               out_ready = 1'b0;
  wire                in_ready;
  wire                out_valid;
  wire                ok;
  wire [START_W-1:0]  start_block;
  wire [FREE_W-1:0]   free_kb;

  int                 errors;
  int                 pending;
  int                 words_checked;
  int                 fits;
  int                 misses;
  int                 clears;
  int                 words_sent     = 0;
  int                 quiet          = 0;
  int unsigned        send_idle_pct  = 0;
  int unsigned        recv_stall_pct = 0;

  always #1 clk = ~clk;

  contiguous_block_allocator i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .size_kb     (size_kb),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ok          (ok),
    .start_block (start_block),
    .free_kb     (free_kb)
  );

  cba_alloc_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .size_kb       (size_kb),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ok            (ok),
    .start_block   (start_block),
    .free_kb       (free_kb),
    .errors        (errors),
    .pending       (pending),
    .words_checked (words_checked),
    .fits          (fits),
    .misses        (misses),
    .clears        (clears)
  );

  always @(posedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("tb_contiguous_block_allocator: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_word(logic act, logic [SIZE_W-1:0] kb);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    size_kb  <= kb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Hold the sender until every pending result word is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return SIZE_W'($urandom_range(3, 0));
    if (r < 70) return SIZE_W'($urandom_range(48, 4));
    if (r < 85) return SIZE_W'($urandom_range(511, 0));
    return SIZE_W'($urandom_range(300, 49));
  endfunction

  // Clear, then fill the map with a burst of requests; a few stray clears.
  task automatic run_phase(int count);
    int target;
    int burst;
    int j;
    target = words_sent + count;
    while (words_sent < target) begin
      send_word(ACT_CLEAR, pick_size());
      burst = $urandom_range(24, 4);
      for (j = 0; j < burst && words_sent < target; j++) begin
        if ($urandom_range(99) < 4) send_word(ACT_CLEAR, pick_size());
        else send_word(ACT_ALLOC, pick_size());
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_word(ACT_ALLOC, 9'd0);
    send_word(ACT_ALLOC, 9'd3);
    send_word(ACT_ALLOC, 9'd4);
    send_word(ACT_ALLOC, 9'd7);
    send_word(ACT_ALLOC, 9'd511);
    send_word(ACT_ALLOC, 9'd260);
    send_word(ACT_ALLOC, 9'd256);
    send_word(ACT_CLEAR, 9'd511);
    send_word(ACT_ALLOC, 9'd252);
    send_word(ACT_ALLOC, 9'd4);
    send_word(ACT_CLEAR, 9'd0);
    send_word(ACT_ALLOC, 9'd244);
    send_word(ACT_ALLOC, 9'd8);
    send_word(ACT_CLEAR, 9'd256);
    send_word(ACT_ALLOC, 9'd248);
    send_word(ACT_ALLOC, 9'd4);
    send_word(ACT_ALLOC, 9'd4);
    send_word(ACT_CLEAR, 9'd255);

    run_phase(130);
    drain();

    send_idle_pct  = 70;
    recv_stall_pct = 0;
    run_phase(135);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 70;
    run_phase(135);
    drain();

    send_idle_pct  = 27;
    recv_stall_pct = 27;
    run_phase(135);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d fits, %0d misses, %0d clears), checked %0d results",
             words_sent, fits, misses, clears, words_checked);
    $display("idling mixes: none, sender 70%%, receiver 70%%, both 27%%");
    if (errors == 0) begin
      $display("tb_contiguous_block_allocator: done, clean");
    end else begin
      $display("tb_contiguous_block_allocator: done, errors");
    end
    $finish;
  end

endmodule
